// ----- src/fastcgi_params_record_parser_assert.svh -----
// ----------------------------------------------------------------------------
// FastCGI parameter record parser: assertion macros
// Concurrent checks clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef FASTCGI_PARAMS_RECORD_PARSER_ASSERT_SVH
`define FASTCGI_PARAMS_RECORD_PARSER_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Consequent must hold in the same cycle as the antecedent.
`define FCGI_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Consequent must hold in the cycle after the antecedent.
`define FCGI_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define FCGI_ASSERT_SAME(label, ante, cons, msg)
`define FCGI_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

// ----- src/fcgi_pkg.sv -----
// ----------------------------------------------------------------------------
// FastCGI parameter record parser: shared package
// Payload types, codes, key name table and sizing constants.
// ----------------------------------------------------------------------------
package fcgi_pkg;

    // Field widths.
    localparam int LIMIT_W    = 16;
    localparam int LEN_W      = 31;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // Longest record that passes the size check.
    localparam int RECORD_BYTES = 32768;

    // Result queue depth, a power of two of at least two.
    localparam int OQ_DEPTH = 4;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_QUERY_LIMIT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_URI_LIMIT    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SERVER_LIMIT = 2'd2;

    // Configuration reset values.
    localparam logic [LIMIT_W-1:0] QUERY_LIMIT_RST  = 16'd2048;
    localparam logic [LIMIT_W-1:0] URI_LIMIT_RST    = 16'd256;
    localparam logic [LIMIT_W-1:0] SERVER_LIMIT_RST = 16'd256;

    // Header constants.
    localparam logic [15:0] HDR_BYTES        = 16'd8;
    localparam logic [7:0]  FCGI_VERSION     = 8'd1;
    localparam logic [7:0]  FCGI_TYPE_PARAMS = 8'd4;

    // Result kinds.
    localparam logic RK_VALUE  = 1'b0;
    localparam logic RK_STATUS = 1'b1;

    // Value tags.
    localparam logic [1:0] TAG_QUERY  = 2'd0;
    localparam logic [1:0] TAG_URI    = 2'd1;
    localparam logic [1:0] TAG_SERVER = 2'd2;
    localparam logic [1:0] TAG_COOKIE = 2'd3;

    // Record status codes, in priority order.
    localparam logic [2:0] ST_OK           = 3'd0;
    localparam logic [2:0] ST_BAD_SIZE     = 3'd1;
    localparam logic [2:0] ST_LEN_MISMATCH = 3'd2;
    localparam logic [2:0] ST_BAD_VERSION  = 3'd3;
    localparam logic [2:0] ST_WRONG_TYPE   = 3'd4;
    localparam logic [2:0] ST_BAD_PAIR     = 3'd5;

    // Parameter names that are matched, one mask bit each.
    localparam int KEY_COUNT   = 5;
    localparam int KEY_QUERY   = 0;
    localparam int KEY_URI     = 1;
    localparam int KEY_SERVER  = 2;
    localparam int KEY_HTTPS   = 3;
    localparam int KEY_COOKIE  = 4;
    localparam int KEY_MAX_LEN = 12;
    localparam int KEY_TEXT_W  = 8 * KEY_MAX_LEN;

    localparam logic [KEY_COUNT-1:0] ALL_NAMES = '1;

    localparam logic [KEY_TEXT_W-1:0] KEY_TEXT [KEY_COUNT] = '{
        {"QUERY", "_STRING"}, {"DOCUMENT", "_URI"}, {"SERVER", "_NAME"}, "HTTPS",
        {"HTTP", "_COOKIE"}
    };
    localparam logic [3:0] KEY_LEN [KEY_COUNT] = '{4'd12, 4'd12, 4'd11, 4'd5, 4'd11};

    // One request on the byte channel.
    typedef struct packed {
        logic [7:0]  data_byte;
        logic        record_end;
        logic [31:0] request_tag;
    } fcgi_in_t;

    // One result item.
    typedef struct packed {
        logic        result_kind;
        logic [1:0]  value_tag;
        logic [7:0]  value_out;
        logic        value_first;
        logic [2:0]  record_status;
        logic        https_seen;
        logic [31:0] tag_out;
        logic        run_last;
    } fcgi_res_t;

    // Length limits from the configuration registers.
    typedef struct packed {
        logic [LIMIT_W-1:0] query;
        logic [LIMIT_W-1:0] uri;
        logic [LIMIT_W-1:0] server;
    } fcgi_limits_t;

    // Results produced by one byte, in delivery order.
    typedef struct packed {
        logic [1:0] count;
        fcgi_res_t  first;
        fcgi_res_t  second;
    } fcgi_push_t;

    // Name matcher outcome for one name byte.
    typedef struct packed {
        logic [KEY_COUNT-1:0] mask;
        logic                 name_end;
        logic                 https_hit;
    } fcgi_match_t;

    // Character of a key name at a position; zero past the end of the table row.
    function automatic logic [7:0] key_char(input logic [KEY_TEXT_W-1:0] txt,
                                            input logic [3:0] klen,
                                            input logic [3:0] pos);
        logic [KEY_TEXT_W-1:0] aligned;
        aligned = txt << (8 * (KEY_MAX_LEN - int'(klen)));
        aligned = aligned << (8 * int'(pos));
        return aligned[KEY_TEXT_W-1 -: 8];
    endfunction

endpackage

// ----- src/fcgi_stream_if.sv -----
// ----------------------------------------------------------------------------
// FastCGI parameter record parser: stream channel
// Valid/ready channel carrying one payload per request.
// ----------------------------------------------------------------------------
interface fcgi_stream_if #(parameter type PAYLOAD_T = logic);

    logic     valid;
    logic     ready;
    PAYLOAD_T payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);

endinterface

// ----- src/fastcgi_params_record_parser.sv -----
// ----------------------------------------------------------------------------
// FastCGI parameter record parser
// Each result is registered in the result queue and is offered from its head.
// Throughput: one byte per cycle while the four-entry result queue has room for two.
// Reset empties the queue, restores the limits to 2048, 256 and 256, starts a record.
// ----------------------------------------------------------------------------
`include "fastcgi_params_record_parser_assert.svh"

module fastcgi_params_record_parser
    import fcgi_pkg::*;
#(
    parameter int MAX_RECORD_BYTES = RECORD_BYTES
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    fcgi_stream_if.sink           byte_ch,
    fcgi_stream_if.source         result_ch
);

    fcgi_limits_t limits_reg;
    fcgi_push_t   push;
    logic         space;
    logic         take;

    assign byte_ch.ready = space;
    assign take          = byte_ch.valid && byte_ch.ready;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limits_reg.query  <= QUERY_LIMIT_RST;
            limits_reg.uri    <= URI_LIMIT_RST;
            limits_reg.server <= SERVER_LIMIT_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_QUERY_LIMIT:  limits_reg.query <= cfg_data[LIMIT_W-1:0];
                CFG_URI_LIMIT:    limits_reg.uri <= cfg_data[LIMIT_W-1:0];
                CFG_SERVER_LIMIT: limits_reg.server <= cfg_data[LIMIT_W-1:0];
                default:          ;
            endcase
        end
    end

    fcgi_parser #(
        .MAX_RECORD_BYTES (MAX_RECORD_BYTES)
    ) u_parser (
        .clk     (clk),
        .rst_n   (rst_n),
        .take    (take),
        .in_item (byte_ch.payload),
        .limits  (limits_reg),
        .push    (push)
    );

    fcgi_out_queue u_out_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .space     (space),
        .result_ch (result_ch)
    );

    // Results come only from accepted requests.
    `FCGI_ASSERT_SAME(a_push_needs_take, push.count != 2'd0, take, "result without a request")

    // A byte causing two results gives the value first and the status last.
    `FCGI_ASSERT_SAME(a_pair_order, push.count == 2'd2, push.first.result_kind == RK_VALUE && !push.first.run_last && push.second.result_kind == RK_STATUS && push.second.run_last, "bad result order")

    // The final byte of a record always leaves a result waiting.
    `FCGI_ASSERT_NEXT(a_status_queued, take && byte_ch.payload.record_end, result_ch.valid, "record end left no result")

endmodule

// ----- src/fcgi_name_match.sv -----
// ----------------------------------------------------------------------------
// FastCGI parameter record parser: name matcher
// Narrows the candidate mask by one name byte and checks the name length
// on the final byte of the name.
// ----------------------------------------------------------------------------
module fcgi_name_match
    import fcgi_pkg::*;
(
    input  logic [KEY_COUNT-1:0] mask,
    input  logic [LEN_W-1:0]     position,
    input  logic [LEN_W-1:0]     nm_length,
    input  logic [7:0]           data_byte,
    output fcgi_match_t          result
);

    logic [KEY_COUNT-1:0] char_hit;
    logic [KEY_COUNT-1:0] len_hit;
    logic [LEN_W-1:0]     pos_inc;
    logic                 pos_small;

    assign pos_small = (position[LEN_W-1:4] == '0);
    assign pos_inc   = position + LEN_W'(1);

    // Per-candidate character and length comparison.
    always_comb
    begin
        for (int i = 0; i < KEY_COUNT; i++)
        begin
            char_hit[i] = pos_small && (position[3:0] < KEY_LEN[i]) &&
                          (key_char(KEY_TEXT[i], KEY_LEN[i], position[3:0]) == data_byte);
            len_hit[i]  = (nm_length == LEN_W'(KEY_LEN[i]));
        end
    end

    // The length check applies only when this byte closes the name.
    always_comb
    begin
        result.name_end  = (pos_inc == nm_length);
        result.mask      = mask & char_hit;
        if (result.name_end)
        begin
            result.mask = result.mask & len_hit;
        end
        result.https_hit = result.name_end && result.mask[KEY_HTTPS];
    end

endmodule

// ----- src/fcgi_parser.sv -----
// ----------------------------------------------------------------------------
// FastCGI parameter record parser: record decoder
// Holds the per-record state, decodes one byte per accepted request and
// produces the value result and the final status result.
// ----------------------------------------------------------------------------
module fcgi_parser
    import fcgi_pkg::*;
#(
    parameter int MAX_RECORD_BYTES = RECORD_BYTES
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         take,
    input  fcgi_in_t     in_item,
    input  fcgi_limits_t limits,
    output fcgi_push_t   push
);

    typedef enum logic [2:0] {
        PH_HEADER,
        PH_NAME_LEN,
        PH_VAL_LEN,
        PH_NAME,
        PH_VALUE,
        PH_TAIL
    } phase_t;

    typedef struct packed {
        logic [LEN_W-1:0] len;
        logic [1:0]       idx;
        logic             done;
    } len_step_t;

    // Header byte offsets.
    localparam logic [2:0] HDR_POS_VERSION = 3'd0;
    localparam logic [2:0] HDR_POS_TYPE    = 3'd1;
    localparam logic [2:0] HDR_POS_CLEN_HI = 3'd4;
    localparam logic [2:0] HDR_POS_CLEN_LO = 3'd5;
    localparam logic [2:0] HDR_POS_PAD     = 3'd6;
    localparam logic [2:0] HDR_POS_LAST    = 3'd7;

    phase_t               phase_reg, phase_next;
    logic [15:0]          byte_count_reg, byte_count_next;
    logic [7:0]           version_reg, version_next;
    logic [7:0]           type_reg, type_next;
    logic [15:0]          clen_reg, clen_next;
    logic [7:0]           pad_reg, pad_next;
    logic [15:0]          body_rem_reg, body_rem_next;
    logic [LEN_W-1:0]     nm_len_reg, nm_len_next;
    logic [LEN_W-1:0]     value_len_reg, value_len_next;
    logic [1:0]           len_idx_reg, len_idx_next;
    logic [LEN_W-1:0]     fpos_reg, fpos_next;
    logic [KEY_COUNT-1:0] mask_reg, mask_next;
    logic                 https_reg, https_next;
    logic                 pair_err_reg, pair_err_next;

    fcgi_match_t          match;
    len_step_t            len_step;
    logic [LEN_W-1:0]     fpos_inc;
    logic [15:0]          body_rem_dec;
    logic                 val_valid;
    logic                 pass;
    logic [1:0]           vtag;
    fcgi_res_t            val_res;
    fcgi_res_t            stat_res;
    logic [16:0]          rec_len;
    logic [16:0]          rec_want;
    logic [2:0]           status;

    // One byte of a 1- or 4-byte pair length.
    function automatic len_step_t take_len(input logic [LEN_W-1:0] cur,
                                           input logic [7:0] b,
                                           input logic [1:0] idx);
        len_step_t r;
        r.len  = cur;
        r.idx  = idx;
        r.done = 1'b0;
        case (idx)
            2'd0:
            begin
                if (!b[7])
                begin
                    r.len  = LEN_W'(b);
                    r.done = 1'b1;
                end
                else
                begin
                    r.len = {b[6:0], 24'd0};
                    r.idx = 2'd1;
                end
            end
            2'd1:
            begin
                r.len[23:16] = b;
                r.idx        = 2'd2;
            end
            2'd2:
            begin
                r.len[15:8] = b;
                r.idx       = 2'd3;
            end
            default:
            begin
                r.len[7:0] = b;
                r.idx      = 2'd0;
                r.done     = 1'b1;
            end
        endcase
        return r;
    endfunction

    fcgi_name_match u_name_match (
        .mask      (mask_reg),
        .position  (fpos_reg),
        .nm_length (nm_len_reg),
        .data_byte (in_item.data_byte),
        .result    (match)
    );

    assign fpos_inc     = fpos_reg + LEN_W'(1);
    assign body_rem_dec = body_rem_reg - 16'd1;
    assign len_step     = take_len((phase_reg == PH_VAL_LEN) ? value_len_reg : nm_len_reg,
                                   in_item.data_byte, len_idx_reg);

    // Value routing and length limits for the current name.
    always_comb
    begin
        pass = 1'b0;
        vtag = TAG_QUERY;
        if (mask_reg[KEY_QUERY])
        begin
            pass = (value_len_reg[LEN_W-1:LIMIT_W] == '0) &&
                   (value_len_reg[LIMIT_W-1:0] < limits.query);
            vtag = TAG_QUERY;
        end
        else if (mask_reg[KEY_URI])
        begin
            pass = (value_len_reg[LEN_W-1:LIMIT_W] == '0) &&
                   (value_len_reg[LIMIT_W-1:0] < limits.uri);
            vtag = TAG_URI;
        end
        else if (mask_reg[KEY_SERVER])
        begin
            pass = (value_len_reg[LEN_W-1:LIMIT_W] == '0) &&
                   (value_len_reg[LIMIT_W-1:0] < limits.server);
            vtag = TAG_SERVER;
        end
        else if (mask_reg[KEY_COOKIE])
        begin
            pass = 1'b1;
            vtag = TAG_COOKIE;
        end
    end

    // Per-byte decode and next state; the final byte is cleared at the register.
    always_comb
    begin
        phase_next      = phase_reg;
        byte_count_next = byte_count_reg;
        version_next    = version_reg;
        type_next       = type_reg;
        clen_next       = clen_reg;
        pad_next        = pad_reg;
        body_rem_next   = body_rem_reg;
        nm_len_next     = nm_len_reg;
        value_len_next  = value_len_reg;
        len_idx_next    = len_idx_reg;
        fpos_next       = fpos_reg;
        mask_next       = mask_reg;
        https_next      = https_reg;
        pair_err_next   = pair_err_reg;
        val_valid       = 1'b0;

        if (take)
        begin
            if (byte_count_reg < HDR_BYTES)
            begin
                // Header bytes.
                case (byte_count_reg[2:0])
                    HDR_POS_VERSION: version_next = in_item.data_byte;
                    HDR_POS_TYPE:    type_next = in_item.data_byte;
                    HDR_POS_CLEN_HI: clen_next[15:8] = in_item.data_byte;
                    HDR_POS_CLEN_LO: clen_next[7:0] = in_item.data_byte;
                    HDR_POS_PAD:     pad_next = in_item.data_byte;
                    default:         ;
                endcase
                if (byte_count_reg[2:0] == HDR_POS_LAST)
                begin
                    body_rem_next = clen_reg;
                    phase_next    = (clen_reg != 16'd0) ? PH_NAME_LEN : PH_TAIL;
                    len_idx_next  = 2'd0;
                end
            end
            else if (phase_reg != PH_TAIL && phase_reg != PH_HEADER)
            begin
                // Body bytes.
                unique case (phase_reg)
                    PH_NAME_LEN:
                    begin
                        nm_len_next  = len_step.len;
                        len_idx_next = len_step.idx;
                        if (len_step.done)
                        begin
                            phase_next = PH_VAL_LEN;
                        end
                    end
                    PH_VAL_LEN:
                    begin
                        value_len_next = len_step.len;
                        len_idx_next   = len_step.idx;
                        if (len_step.done)
                        begin
                            mask_next = ALL_NAMES;
                            fpos_next = '0;
                            if (nm_len_reg != '0)
                            begin
                                phase_next = PH_NAME;
                            end
                            else
                            begin
                                mask_next  = '0;
                                phase_next = (len_step.len != '0) ? PH_VALUE : PH_NAME_LEN;
                            end
                        end
                    end
                    PH_NAME:
                    begin
                        mask_next = match.mask;
                        fpos_next = fpos_inc;
                        if (match.name_end)
                        begin
                            if (match.https_hit)
                            begin
                                https_next = 1'b1;
                            end
                            fpos_next  = '0;
                            phase_next = (value_len_reg != '0) ? PH_VALUE : PH_NAME_LEN;
                        end
                    end
                    PH_VALUE:
                    begin
                        val_valid = pass && (version_reg == FCGI_VERSION) &&
                                    (type_reg == FCGI_TYPE_PARAMS);
                        fpos_next = fpos_inc;
                        if (fpos_inc == value_len_reg)
                        begin
                            fpos_next  = '0;
                            phase_next = PH_NAME_LEN;
                        end
                    end
                    default: ;
                endcase

                // Body accounting; a pair cut off by the body end is an error.
                body_rem_next = body_rem_dec;
                if (body_rem_dec == 16'd0)
                begin
                    if (phase_next != PH_NAME_LEN || len_idx_next != 2'd0)
                    begin
                        pair_err_next = 1'b1;
                    end
                    phase_next = PH_TAIL;
                end
            end

            if (byte_count_reg != 16'hFFFF)
            begin
                byte_count_next = byte_count_reg + 16'd1;
            end
        end
    end

    // Record status, first failing check wins, on the state as this byte leaves it.
    always_comb
    begin
        rec_len  = 17'(byte_count_reg) + 17'd1;
        rec_want = 17'(HDR_BYTES) + 17'(clen_next) + 17'(pad_next);
        if (rec_len < 17'(HDR_BYTES) || rec_len > 17'(MAX_RECORD_BYTES))
        begin
            status = ST_BAD_SIZE;
        end
        else if (rec_len != rec_want)
        begin
            status = ST_LEN_MISMATCH;
        end
        else if (version_next != FCGI_VERSION)
        begin
            status = ST_BAD_VERSION;
        end
        else if (type_next != FCGI_TYPE_PARAMS)
        begin
            status = ST_WRONG_TYPE;
        end
        else if (pair_err_next)
        begin
            status = ST_BAD_PAIR;
        end
        else
        begin
            status = ST_OK;
        end
    end

    // Result assembly.
    always_comb
    begin
        val_res               = '0;
        val_res.result_kind   = RK_VALUE;
        val_res.value_tag     = vtag;
        val_res.value_out     = in_item.data_byte;
        val_res.value_first   = (fpos_reg == '0);
        val_res.run_last      = !in_item.record_end;

        stat_res               = '0;
        stat_res.result_kind   = RK_STATUS;
        stat_res.record_status = status;
        stat_res.https_seen    = https_next;
        stat_res.tag_out       = in_item.request_tag;
        stat_res.run_last      = 1'b1;

        push = '0;
        if (take)
        begin
            if (val_valid && in_item.record_end)
            begin
                push.count  = 2'd2;
                push.first  = val_res;
                push.second = stat_res;
            end
            else if (val_valid)
            begin
                push.count = 2'd1;
                push.first = val_res;
            end
            else if (in_item.record_end)
            begin
                push.count = 2'd1;
                push.first = stat_res;
            end
        end
    end

    // Control state; the final byte of a record starts a fresh one.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_HEADER;
            byte_count_reg <= '0;
            version_reg    <= '0;
            type_reg       <= '0;
            clen_reg       <= '0;
            pad_reg        <= '0;
            body_rem_reg   <= '0;
            nm_len_reg     <= '0;
            value_len_reg  <= '0;
            len_idx_reg    <= '0;
            fpos_reg       <= '0;
            mask_reg       <= ALL_NAMES;
            https_reg      <= 1'b0;
            pair_err_reg   <= 1'b0;
        end
        else if (take && in_item.record_end)
        begin
            phase_reg      <= PH_HEADER;
            byte_count_reg <= '0;
            version_reg    <= '0;
            type_reg       <= '0;
            clen_reg       <= '0;
            pad_reg        <= '0;
            body_rem_reg   <= '0;
            nm_len_reg     <= '0;
            value_len_reg  <= '0;
            len_idx_reg    <= '0;
            fpos_reg       <= '0;
            mask_reg       <= ALL_NAMES;
            https_reg      <= 1'b0;
            pair_err_reg   <= 1'b0;
        end
        else
        begin
            phase_reg      <= phase_next;
            byte_count_reg <= byte_count_next;
            version_reg    <= version_next;
            type_reg       <= type_next;
            clen_reg       <= clen_next;
            pad_reg        <= pad_next;
            body_rem_reg   <= body_rem_next;
            nm_len_reg     <= nm_len_next;
            value_len_reg  <= value_len_next;
            len_idx_reg    <= len_idx_next;
            fpos_reg       <= fpos_next;
            mask_reg       <= mask_next;
            https_reg      <= https_next;
            pair_err_reg   <= pair_err_next;
        end
    end

endmodule

// ----- src/fcgi_out_queue.sv -----
// ----------------------------------------------------------------------------
// FastCGI parameter record parser: result queue
// Small register queue that takes up to two results a cycle and hands one
// result a cycle to the result channel while the channel is ready.
// ----------------------------------------------------------------------------
module fcgi_out_queue
    import fcgi_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  fcgi_push_t        push,
    output logic              space,
    fcgi_stream_if.source     result_ch
);

    localparam int OQ_AW = $clog2(OQ_DEPTH);
    localparam int OQ_CW = $clog2(OQ_DEPTH + 1);

    fcgi_res_t        mem_reg [OQ_DEPTH];
    logic [OQ_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [OQ_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [OQ_CW-1:0] count_reg, count_next;
    logic             pop;

    // Head of the queue drives the channel.
    assign result_ch.valid   = (count_reg != '0);
    assign result_ch.payload = mem_reg[rd_ptr_reg];
    assign pop               = result_ch.valid && result_ch.ready;

    // Room for the two results one byte may cause.
    assign space = (count_reg <= OQ_CW'(OQ_DEPTH - 2));

    // Pointer and fill bookkeeping.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + OQ_AW'(push.count);
        rd_ptr_next = rd_ptr_reg + OQ_AW'(pop);
        count_next  = count_reg + OQ_CW'(push.count) - OQ_CW'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Result storage.
    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
        begin
            mem_reg[wr_ptr_reg] <= push.first;
        end
        if (push.count == 2'd2)
        begin
            mem_reg[wr_ptr_reg + OQ_AW'(1)] <= push.second;
        end
    end

endmodule
